/* rtl/cgmq_pkg.sv */
// Shared types and constants of the credit-gated multi-queue FIFO.
// No dependencies; imported by the top level and the slot memory.
`default_nettype none

package cgmq_pkg;

  // Field widths fixed by the command format.
  localparam int ID_W  = 32;
  localparam int CNT_W = 16;

  // Queues 0 up to CREDITED-1 keep credit accounting.
  localparam int CREDITED = 3;

  // Command codes.
  localparam logic [1:0] CMD_PUSH    = 2'd0;
  localparam logic [1:0] CMD_POP     = 2'd1;
  localparam logic [1:0] CMD_RELEASE = 2'd2;
  localparam logic [1:0] CMD_QUERY   = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DECODE_LIMIT     = 2'd0;
  localparam logic [1:0] CFG_REWARD_LIMIT     = 2'd1;
  localparam logic [1:0] CFG_TRAJECTORY_LIMIT = 2'd2;

  // Access controls toward the slot memory.
  typedef struct packed {
    logic we;
    logic re;
  } ram_ctl_t;

endpackage : cgmq_pkg

`default_nettype wire

/* rtl/cgmq_slot_ram.sv */
// Single-port slot memory holding the ids of all rings.
// Depends on cgmq_pkg for the id width and the access control struct.
`default_nettype none

module cgmq_slot_ram
  import cgmq_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic          clk_i,
  input  wire ram_ctl_t      ctl_i,
  input  wire logic [AW-1:0] addr_i,
  input  wire logic [ID_W-1:0] wdata_i,
  output logic [ID_W-1:0]    rdata_o
);

  logic [ID_W-1:0] mem [DEPTH];
  logic [ID_W-1:0] rdata_q;

  // Write on push, registered read on pop; the read data holds between reads.
  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem[addr_i] <= wdata_i;
    end
    if (ctl_i.re) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule : cgmq_slot_ram

`default_nettype wire

/* rtl/credit_gated_multi_queue_fifo_top.sv */
// Top level of the credit-gated multi-queue FIFO.
// Depends on cgmq_pkg and instantiates cgmq_slot_ram.
//
// Usage: commands (push, pop, release credits, query) enter on the input
// valid/ready channel; every command yields exactly one result transaction on
// the output valid/ready channel, in order. Pointers and credit counts live
// in flip-flops and are updated at the edge where a command is accepted, so
// the following command already sees them. The ids sit in one shared slot
// memory with a registered read; a pop reads its slot at acceptance and the
// data joins the result as it moves into the output register.
// Throughput: one command per cycle while the receiver keeps ready high.
// Path: a result waits in the first stage for the slot read, then moves on
// into the output register.
// Stalls: when the receiver holds ready low, the output register and one
// stage behind it keep their results and the input channel keeps taking
// commands until both are full.
// Reset: pointers, credit counts and limits clear at once; the slot memory
// needs no clearing since a slot is always written before it is read.
// Configuration writes take effect at the edge where the write enable is high.
`default_nettype none

module credit_gated_multi_queue_fifo_top
  import cgmq_pkg::*;
#(
  parameter int RING_DEPTH = 256,
  parameter int NUM_QUEUES = 4,
  localparam int OCC_W = $clog2(RING_DEPTH + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // Configuration write port.
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_idx_i,
  input  wire logic [CNT_W-1:0]  cfg_data_i,
  // Command channel.
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        cmd_i,
  input  wire logic [1:0]        queue_sel_i,
  input  wire logic [ID_W-1:0]   entry_id_i,
  input  wire logic [CNT_W-1:0]  release_count_i,
  input  wire logic [CNT_W-1:0]  max_batch_i,
  // Result channel.
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   status_o,
  output logic [ID_W-1:0]        id_out_o,
  output logic [OCC_W-1:0]       occupancy_o,
  output logic [CNT_W-1:0]       credit_headroom_o,
  output logic                   headroom_unlimited_o,
  output logic [OCC_W-1:0]       target_batch_o
);

  localparam int SLOTS  = NUM_QUEUES * RING_DEPTH;
  localparam int AW     = $clog2(SLOTS);
  localparam int PTR_W  = $clog2(2 * RING_DEPTH);
  localparam int QIDX_W = $clog2(NUM_QUEUES);
  localparam int CMP_W  = (OCC_W > CNT_W) ? OCC_W : CNT_W;

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(2 * RING_DEPTH - 1);
  localparam logic [PTR_W-1:0] PTR_HALF = PTR_W'(RING_DEPTH);
  localparam logic [PTR_W:0]   PTR_MOD  = (PTR_W + 1)'(2 * RING_DEPTH);
  localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(RING_DEPTH);
  localparam logic [CNT_W-1:0] CNT_MAX  = {CNT_W{1'b1}};

  // Control state.
  logic [PTR_W-1:0] wp_q [NUM_QUEUES];
  logic [PTR_W-1:0] rp_q [NUM_QUEUES];
  logic [CNT_W-1:0] cu_q  [CREDITED];
  logic [CNT_W-1:0] lim_q [CREDITED];

  // Decode of the current command.
  logic              acc;
  logic              qv;
  logic              cred;
  logic [QIDX_W-1:0] sidx;
  logic [1:0]        cidx;
  logic [PTR_W-1:0]  wp;
  logic [PTR_W-1:0]  rp;
  logic [PTR_W-1:0]  wp_inc;
  logic [PTR_W-1:0]  rp_inc;
  logic [PTR_W-1:0]  slot_ptr;
  logic [PTR_W-1:0]  slot_pos;
  logic [PTR_W:0]    fill_wide;
  logic [OCC_W-1:0]  fill;
  logic [CNT_W-1:0]  cu;
  logic [CNT_W-1:0]  lim;
  logic              push_ok;
  logic              pop_ok;
  logic              refused;
  logic [OCC_W-1:0]  occ_a;
  logic [CNT_W-1:0]  cu_a;
  logic [CNT_W-1:0]  head;
  logic [CNT_W-1:0]  bound;
  logic [CMP_W-1:0]  bound_w;
  logic [OCC_W-1:0]  tgt;

  // Memory access.
  ram_ctl_t          ram_ctl;
  logic [AW-1:0]     ram_addr;
  logic [ID_W-1:0]   ram_rdata;

  // Stage behind the memory read, then the output register.
  logic              s1_valid_q;
  logic              s1_status_q;
  logic              s1_pop_q;
  logic [OCC_W-1:0]  s1_occ_q;
  logic [CNT_W-1:0]  s1_head_q;
  logic              s1_unlim_q;
  logic [OCC_W-1:0]  s1_tgt_q;
  logic              s1_adv;

  logic              out_valid_q;
  logic              out_status_q;
  logic [ID_W-1:0]   out_id_q;
  logic [OCC_W-1:0]  out_occ_q;
  logic [CNT_W-1:0]  out_head_q;
  logic              out_unlim_q;
  logic [OCC_W-1:0]  out_tgt_q;

  // Handshake: the output register drains, the first stage refills it.
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign acc        = in_valid_i && in_ready_o;

  // Queue selection and the selected ring's pointers and credits.
  always_comb begin
    qv   = (32'(queue_sel_i) < NUM_QUEUES);
    cred = qv && (32'(queue_sel_i) < CREDITED);
    sidx = qv ? QIDX_W'(queue_sel_i) : '0;
    cidx = cred ? queue_sel_i : '0;
    wp   = wp_q[sidx];
    rp   = rp_q[sidx];
    cu   = cred ? cu_q[cidx]  : '0;
    lim  = cred ? lim_q[cidx] : '0;

    wp_inc = (wp == PTR_LAST) ? '0 : wp + 1'b1;
    rp_inc = (rp == PTR_LAST) ? '0 : rp + 1'b1;

    // Pointers count modulo twice the depth so that full and empty differ.
    if (wp >= rp) begin
      fill_wide = {1'b0, wp} - {1'b0, rp};
    end else begin
      fill_wide = {1'b0, wp} + PTR_MOD - {1'b0, rp};
    end
    fill = OCC_W'(fill_wide);
  end

  // Command execution and the values reported after it.
  always_comb begin
    push_ok = 1'b0;
    pop_ok  = 1'b0;
    refused = !qv;
    occ_a   = fill;
    cu_a    = cu;
    case (cmd_i)
      CMD_PUSH: begin
        if ((cred && (lim != '0) && (cu >= lim)) || (fill >= OCC_FULL)) begin
          refused = 1'b1;
        end else begin
          push_ok = qv;
          occ_a   = fill + 1'b1;
          if (cu != CNT_MAX) begin
            cu_a = cu + 1'b1;
          end
        end
      end
      CMD_POP: begin
        if (fill == '0) begin
          refused = 1'b1;
        end else begin
          pop_ok = qv;
          occ_a  = fill - 1'b1;
        end
      end
      CMD_RELEASE: begin
        cu_a = (release_count_i > cu) ? '0 : cu - release_count_i;
      end
      CMD_QUERY: begin
        cu_a = cu;
      end
      default: begin
        cu_a = cu;
      end
    endcase

    // Headroom and target batch from the updated counts.
    head    = (lim > cu_a) ? lim - cu_a : '0;
    bound   = (cred && (head < max_batch_i)) ? head : max_batch_i;
    bound_w = CMP_W'(bound);
    tgt     = (CMP_W'(occ_a) < bound_w) ? occ_a : OCC_W'(bound_w);
  end

  // Slot address: ring base plus the pointer folded into the ring.
  always_comb begin
    slot_ptr    = pop_ok ? rp : wp;
    slot_pos    = (slot_ptr >= PTR_HALF) ? slot_ptr - PTR_HALF : slot_ptr;
    ram_addr    = AW'(32'(sidx) * RING_DEPTH + 32'(slot_pos));
    ram_ctl.we  = acc && push_ok;
    ram_ctl.re  = acc && pop_ok;
  end

  cgmq_slot_ram #(
    .DEPTH (SLOTS),
    .AW    (AW)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .ctl_i   (ram_ctl),
    .addr_i  (ram_addr),
    .wdata_i (entry_id_i),
    .rdata_o (ram_rdata)
  );

  // Pointer and credit updates at acceptance.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        wp_q[i] <= '0;
        rp_q[i] <= '0;
      end
      for (int i = 0; i < CREDITED; i++) begin
        cu_q[i] <= '0;
      end
    end else if (acc) begin
      if (push_ok) begin
        wp_q[sidx] <= wp_inc;
      end
      if (pop_ok) begin
        rp_q[sidx] <= rp_inc;
      end
      if (cred) begin
        cu_q[cidx] <= cu_a;
      end
    end
  end

  // Credit limit registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CREDITED; i++) begin
        lim_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DECODE_LIMIT:     lim_q[0] <= cfg_data_i;
        CFG_REWARD_LIMIT:     lim_q[1] <= cfg_data_i;
        CFG_TRAJECTORY_LIMIT: lim_q[2] <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Valid flags of the two result stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payloads; the popped id joins as the result moves into the output register.
  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_status_q <= refused;
      s1_pop_q    <= pop_ok;
      s1_occ_q    <= qv ? occ_a : '0;
      s1_head_q   <= cred ? head : '0;
      s1_unlim_q  <= !cred;
      s1_tgt_q    <= qv ? tgt : '0;
    end
    if (s1_adv) begin
      out_status_q <= s1_status_q;
      out_id_q     <= s1_pop_q ? ram_rdata : '0;
      out_occ_q    <= s1_occ_q;
      out_head_q   <= s1_head_q;
      out_unlim_q  <= s1_unlim_q;
      out_tgt_q    <= s1_tgt_q;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign status_o             = out_status_q;
  assign id_out_o             = out_id_q;
  assign occupancy_o          = out_occ_q;
  assign credit_headroom_o    = out_head_q;
  assign headroom_unlimited_o = out_unlim_q;
  assign target_batch_o       = out_tgt_q;

  // A result waiting behind a stalled output register keeps its contents.
  a_s1_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=>
      (s1_valid_q && $stable(s1_occ_q) && $stable(s1_pop_q) && $stable(s1_tgt_q)))
    else $error("first result stage changed while stalled");

  // The selected ring never holds more entries than its depth.
  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && qv) |-> (fill <= OCC_FULL))
    else $error("ring fill exceeds its depth");

  // A refused command never carries an id.
  a_refused_no_id : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> (id_out_o == '0))
    else $error("refused result carries an id");

  // The target batch never exceeds the occupancy it reports.
  a_target_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (target_batch_o <= occupancy_o))
    else $error("target batch above occupancy");

endmodule : credit_gated_multi_queue_fifo_top

`default_nettype wire

/* bench/testbench.sv */
// Self-checking bench for the credit-gated multi-queue FIFO: push, pop, release, query.
// Depends on cgmq_pkg and credit_gated_multi_queue_fifo_top; a queue model
// predicts every response at acceptance and the monitor checks it in order.
module testbench
  import cgmq_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_DEPTH = 256;
  localparam int NUM_QUEUES = 4;
  localparam int OCC_W = $clog2(RING_DEPTH + 1);
  localparam int PTR_W = $clog2(2 * RING_DEPTH);
  localparam int MAX_CYCLES = 1000000;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [1:0] CFG_UNUSED_IDX = 2'd3;

  typedef struct {
    logic [1:0]       op;
    logic [1:0]       qsel;
    logic [ID_W-1:0]  entry;
    logic [CNT_W-1:0] rel_count;
    logic [CNT_W-1:0] batch;
  } command_t;

  typedef struct {
    logic             status;
    logic [ID_W-1:0]  id_out;
    logic [OCC_W-1:0] occupancy;
    logic [CNT_W-1:0] headroom;
    logic             unlimited;
    logic [OCC_W-1:0] target;
  } response_t;

  // Block ports.
  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [1:0]       cfg_idx_i = '0;
  logic [CNT_W-1:0] cfg_data_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [1:0]       cmd_i = '0;
  logic [1:0]       queue_sel_i = '0;
  logic [ID_W-1:0]  entry_id_i = '0;
  logic [CNT_W-1:0] release_count_i = '0;
  logic [CNT_W-1:0] max_batch_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic             status_o;
  logic [ID_W-1:0]  id_out_o;
  logic [OCC_W-1:0] occupancy_o;
  logic [CNT_W-1:0] credit_headroom_o;
  logic             headroom_unlimited_o;
  logic [OCC_W-1:0] target_batch_o;

  // Model state of the queues.
  logic [ID_W-1:0]  slot_copy [NUM_QUEUES][RING_DEPTH];
  logic [PTR_W-1:0] wr_ptr [NUM_QUEUES];
  logic [PTR_W-1:0] rd_ptr [NUM_QUEUES];
  logic [CNT_W-1:0] used_credits [NUM_QUEUES];
  logic [CNT_W-1:0] limit_copy [NUM_QUEUES];

  command_t  command_backlog [$];
  response_t expected_responses [$];

  int mismatch_count = 0;
  int cycle_count = 0;
  bit fast_mode = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = 0;
  int mode_left = 0;

  credit_gated_multi_queue_fifo_top #(
    .RING_DEPTH(RING_DEPTH),
    .NUM_QUEUES(NUM_QUEUES)
  ) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .cmd_i(cmd_i),
    .queue_sel_i(queue_sel_i),
    .entry_id_i(entry_id_i),
    .release_count_i(release_count_i),
    .max_batch_i(max_batch_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_o(status_o),
    .id_out_o(id_out_o),
    .occupancy_o(occupancy_o),
    .credit_headroom_o(credit_headroom_o),
    .headroom_unlimited_o(headroom_unlimited_o),
    .target_batch_o(target_batch_o)
  );

  // Free-running clock.
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Applies one command to the model queues and returns the response it yields.
  function automatic response_t predict_response(input command_t c);
    response_t r;
    int q;
    bit credited;
    bit no_credit;
    logic [PTR_W-1:0] fill;
    logic [CNT_W-1:0] head;
    logic [CNT_W-1:0] tgt;
    r = '{default: '0};
    r.unlimited = 1'b1;
    q = c.qsel;
    if (q >= NUM_QUEUES) begin
      r.status = 1'b1;
    end else begin
      credited = (q < CREDITED);
      fill = wr_ptr[q] - rd_ptr[q];
      case (c.op)
        CMD_PUSH: begin
          no_credit = credited && (limit_copy[q] != 0) &&
                      (used_credits[q] >= limit_copy[q]);
          if (no_credit || fill >= RING_DEPTH) begin
            r.status = 1'b1;
          end else begin
            slot_copy[q][wr_ptr[q] % RING_DEPTH] = c.entry;
            wr_ptr[q] = wr_ptr[q] + 1'b1;
            if (credited && used_credits[q] != {CNT_W{1'b1}})
              used_credits[q] = used_credits[q] + 1'b1;
          end
        end
        CMD_POP: begin
          if (fill == 0) begin
            r.status = 1'b1;
          end else begin
            r.id_out = slot_copy[q][rd_ptr[q] % RING_DEPTH];
            rd_ptr[q] = rd_ptr[q] + 1'b1;
          end
        end
        CMD_RELEASE: begin
          if (credited)
            used_credits[q] = (c.rel_count > used_credits[q]) ?
                              '0 : used_credits[q] - c.rel_count;
        end
        default: begin
        end
      endcase

      // Every command reports the queue as it stands afterwards.
      fill = wr_ptr[q] - rd_ptr[q];
      r.occupancy = fill;
      tgt = c.batch;
      if (credited) begin
        r.unlimited = 1'b0;
        head = (limit_copy[q] > used_credits[q]) ? limit_copy[q] - used_credits[q] : '0;
        r.headroom = head;
        if (head < tgt)
          tgt = head;
      end
      if (CNT_W'(fill) < tgt)
        tgt = CNT_W'(fill);
      r.target = tgt[OCC_W-1:0];
    end
    return r;
  endfunction

  // Driver: presents queued commands in bursts, holding each until accepted.
  always @(posedge clk_i) begin : drive_commands
    bit go;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        expected_responses.push_back(predict_response(command_backlog.pop_front()));
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0 && !fast_mode) begin
          gap_left = gap_left - 1;
          go = 1'b0;
        end else begin
          go = (command_backlog.size() != 0);
        end
        if (go) begin
          cmd_i           <= command_backlog[0].op;
          queue_sel_i     <= command_backlog[0].qsel;
          entry_id_i      <= command_backlog[0].entry;
          release_count_i <= command_backlog[0].rel_count;
          max_batch_i     <= command_backlog[0].batch;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            case ($urandom_range(0, 7))
              0, 1: gap_left = 0;
              7: gap_left = $urandom_range(5, 12);
              default: gap_left = $urandom_range(1, 4);
            endcase
          end else begin
            burst_left = burst_left - 1;
          end
        end
        in_valid_i <= go;
      end
    end
  end

  // Reports one field that differs from its prediction.
  task automatic check_field(input string name, input logic [ID_W-1:0] want,
                             input logic [ID_W-1:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Monitor: checks each response transaction against the oldest prediction.
  always @(posedge clk_i) begin : collect_responses
    response_t want;
    bit rdy;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_responses.size() == 0) begin
          $display("%0t ns: response with none expected, expected nothing, actual status %0h",
                   $time, status_o);
          mismatch_count++;
        end else begin
          want = expected_responses.pop_front();
          check_field("status", ID_W'(want.status), ID_W'(status_o));
          check_field("id_out", want.id_out, id_out_o);
          check_field("occupancy", ID_W'(want.occupancy), ID_W'(occupancy_o));
          check_field("credit_headroom", ID_W'(want.headroom), ID_W'(credit_headroom_o));
          check_field("headroom_unlimited", ID_W'(want.unlimited),
                      ID_W'(headroom_unlimited_o));
          check_field("target_batch", ID_W'(want.target), ID_W'(target_batch_o));
        end
      end

      // Receiver back-pressure switches between several stall patterns.
      if (fast_mode) begin
        rdy = 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
        end
        mode_left = mode_left - 1;
        case (stall_mode)
          0: rdy = 1'b1;
          1: rdy = 1'($urandom_range(0, 1));
          2: rdy = ($urandom_range(0, 3) != 0);
          default: rdy = ((mode_left % 32) < 4);
        endcase
      end
      out_ready_i <= rdy;
    end
  end

  task automatic add_cmd(input logic [1:0] op, input logic [1:0] qsel,
                         input logic [ID_W-1:0] entry, input logic [CNT_W-1:0] rel_count,
                         input logic [CNT_W-1:0] batch);
    command_t c;
    c.op = op;
    c.qsel = qsel;
    c.entry = entry;
    c.rel_count = rel_count;
    c.batch = batch;
    command_backlog.push_back(c);
  endtask

  // Release amounts are mostly small so that credits stay near their limits.
  function automatic logic [CNT_W-1:0] pick_release();
    case ($urandom_range(0, 9))
      0: return CNT_W'($urandom());
      1, 2, 3: return CNT_W'($urandom_range(0, 20));
      default: return CNT_W'($urandom_range(0, 3));
    endcase
  endfunction

  function automatic logic [CNT_W-1:0] pick_batch();
    if ($urandom_range(0, 1) != 0)
      return CNT_W'($urandom());
    return CNT_W'($urandom_range(0, 300));
  endfunction

  // Mixed traffic; pushes are favored so that queues build up some depth.
  task automatic add_random_cmds(input int n, input bit release_heavy);
    logic [1:0] op;
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 19);
      if (pick < 8)
        op = CMD_PUSH;
      else if (pick < (release_heavy ? 12 : 14))
        op = CMD_POP;
      else if (pick < (release_heavy ? 17 : 17))
        op = CMD_RELEASE;
      else
        op = CMD_QUERY;
      add_cmd(op, 2'($urandom_range(0, 3)), ID_W'($urandom()), pick_release(),
              pick_batch());
    end
  endtask

  // Waits until every command is accepted and every response has been checked.
  task automatic wait_idle();
    while (command_backlog.size() != 0 || in_valid_i || expected_responses.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [1:0] idx, input logic [CNT_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    if (idx < CREDITED)
      limit_copy[idx] = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Stimulus sequence.
  initial begin : stimulus
    int fill_q;
    int n;
    for (int q = 0; q < NUM_QUEUES; q++) begin
      wr_ptr[q] = '0;
      rd_ptr[q] = '0;
      used_credits[q] = '0;
      limit_copy[q] = '0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: empty queues, uncredited release, extreme ids, release to zero.
    for (int q = 0; q < NUM_QUEUES; q++)
      add_cmd(CMD_QUERY, 2'(q), '0, '0, 16'hFFFF);
    add_cmd(CMD_POP, 2'd0, '0, '0, 16'hFFFF);
    add_cmd(CMD_RELEASE, 2'd3, '0, 16'hFFFF, 16'hFFFF);
    add_cmd(CMD_PUSH, 2'd0, 32'hFFFF_FFFF, '0, 16'hFFFF);
    add_cmd(CMD_PUSH, 2'd0, 32'h0000_0000, '0, 16'h0000);
    add_cmd(CMD_PUSH, 2'd3, 32'hA5A5_5A5A, 16'hFFFF, 16'hFFFF);
    add_cmd(CMD_POP, 2'd0, '0, '0, 16'hFFFF);
    add_cmd(CMD_POP, 2'd3, '0, '0, 16'hFFFF);
    add_cmd(CMD_RELEASE, 2'd0, '0, 16'hFFFF, 16'hFFFF);
    wait_idle();

    // Directed: a small credit limit refuses the third push.
    write_limit(CFG_REWARD_LIMIT, 16'd2);
    write_limit(CFG_TRAJECTORY_LIMIT, 16'hFFFF);
    write_limit(CFG_UNUSED_IDX, 16'h1234);
    add_cmd(CMD_PUSH, 2'd1, 32'h1111_1111, '0, 16'hFFFF);
    add_cmd(CMD_PUSH, 2'd1, 32'h2222_2222, '0, 16'hFFFF);
    add_cmd(CMD_PUSH, 2'd1, 32'h3333_3333, '0, 16'hFFFF);
    add_cmd(CMD_QUERY, 2'd1, '0, '0, 16'h0000);
    add_cmd(CMD_RELEASE, 2'd1, '0, 16'd1, 16'hFFFF);
    add_cmd(CMD_PUSH, 2'd1, 32'h4444_4444, '0, 16'hFFFF);
    add_cmd(CMD_POP, 2'd1, '0, '0, 16'hFFFF);
    add_cmd(CMD_POP, 2'd1, '0, '0, 16'hFFFF);
    add_cmd(CMD_POP, 2'd1, '0, '0, 16'hFFFF);
    add_cmd(CMD_POP, 2'd1, '0, '0, 16'hFFFF);
    add_cmd(CMD_PUSH, 2'd2, 32'h5555_AAAA, '0, 16'hFFFF);
    add_cmd(CMD_QUERY, 2'd0, '0, '0, 16'hFFFF);
    wait_idle();

    // Random traffic under small and unlimited limits.
    write_limit(CFG_DECODE_LIMIT, '0);
    write_limit(CFG_REWARD_LIMIT, CNT_W'($urandom_range(1, 8)));
    write_limit(CFG_TRAJECTORY_LIMIT, CNT_W'($urandom()));
    add_random_cmds(160, 1'b0);
    wait_idle();

    // Fill one ring past full, then drain it past empty.
    write_limit(CFG_DECODE_LIMIT, '0);
    write_limit(CFG_REWARD_LIMIT, 16'hFFFF);
    case ($urandom_range(0, 2))
      0: fill_q = 0;
      1: fill_q = 1;
      default: fill_q = 3;
    endcase
    n = int'(PTR_W'(wr_ptr[fill_q] - rd_ptr[fill_q]));
    for (int i = n; i < RING_DEPTH + 1; i++) begin
      add_cmd(CMD_PUSH, 2'(fill_q), ID_W'($urandom()), pick_release(), pick_batch());
      if ($urandom_range(0, 15) == 0)
        add_cmd(CMD_QUERY, 2'(fill_q), ID_W'($urandom()), pick_release(), pick_batch());
    end
    for (int i = 0; i < RING_DEPTH + 1; i++) begin
      add_cmd(CMD_POP, 2'(fill_q), ID_W'($urandom()), pick_release(), pick_batch());
      if ($urandom_range(0, 15) == 0)
        add_cmd(CMD_QUERY, 2'(fill_q), ID_W'($urandom()), pick_release(), pick_batch());
    end
    wait_idle();

    // Random traffic under wide and tight limits.
    write_limit(CFG_DECODE_LIMIT, CNT_W'($urandom()));
    write_limit(CFG_REWARD_LIMIT, 16'd1);
    write_limit(CFG_TRAJECTORY_LIMIT, 16'd2);
    add_random_cmds(300, 1'b0);
    wait_idle();
    write_limit(CFG_DECODE_LIMIT, CNT_W'($urandom_range(1, 4)));
    write_limit(CFG_REWARD_LIMIT, CNT_W'($urandom_range(1, 4)));
    write_limit(CFG_TRAJECTORY_LIMIT, CNT_W'($urandom_range(1, 4)));
    add_random_cmds(300, 1'b1);
    wait_idle();

    // Back-to-back push/pop pairs on queue 0 with no stalls on either side.
    write_limit(CFG_DECODE_LIMIT, '0);
    fast_mode = 1'b1;
    n = int'(PTR_W'(wr_ptr[0] - rd_ptr[0]));
    for (int i = 0; i < n; i++)
      add_cmd(CMD_POP, 2'd0, '0, '0, 16'hFFFF);
    add_cmd(CMD_RELEASE, 2'd0, '0, 16'hFFFF, 16'hFFFF);
    for (int i = 0; i < 8; i++) begin
      add_cmd(CMD_PUSH, 2'd0, ID_W'($urandom()), '0, 16'hFFFF);
      add_cmd(CMD_POP, 2'd0, '0, '0, 16'hFFFF);
    end
    add_cmd(CMD_PUSH, 2'd0, ID_W'($urandom()), '0, 16'hFFFF);
    add_cmd(CMD_QUERY, 2'd0, '0, '0, 16'hFFFF);
    wait_idle();
    fast_mode = 1'b0;

    // Used count against the largest limit.
    write_limit(CFG_DECODE_LIMIT, 16'hFFFF);
    add_cmd(CMD_PUSH, 2'd0, ID_W'($urandom()), '0, 16'hFFFF);
    add_cmd(CMD_RELEASE, 2'd0, '0, 16'd1, 16'hFFFF);
    add_cmd(CMD_QUERY, 2'd0, '0, '0, 16'hFFFF);
    add_cmd(CMD_PUSH, 2'd0, ID_W'($urandom()), '0, 16'hFFFF);
    add_cmd(CMD_PUSH, 2'd0, ID_W'($urandom()), '0, 16'hFFFF);
    add_cmd(CMD_POP, 2'd0, '0, '0, 16'hFFFF);
    add_cmd(CMD_POP, 2'd0, '0, '0, 16'hFFFF);
    add_cmd(CMD_POP, 2'd0, '0, '0, 16'hFFFF);

    // Let everything drain, then give the verdict.
    while (command_backlog.size() != 0 || in_valid_i || expected_responses.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_responses.size() != 0)
      $display("%0t ns: responses missing, expected %0d more, actual 0",
               $time, expected_responses.size());
    if (mismatch_count == 0 && expected_responses.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
